// ----- sv/ifca_pkg.sv -----
// ifca_pkg: shared constants for the input focus client arbiter
// request, switch mode, status and event codes, parameter defaults, scan flag struct
// no dependencies
package ifca_pkg;

    localparam int MAX_CLIENTS_DEF = 16;
    localparam int PID_BITS_DEF    = 22;

    // request types
    localparam logic [2:0] REQ_CONNECT    = 3'd0;
    localparam logic [2:0] REQ_DISCONNECT = 3'd1;
    localparam logic [2:0] REQ_REG_PID    = 3'd2;
    localparam logic [2:0] REQ_HIDE       = 3'd3;
    localparam logic [2:0] REQ_SWITCH     = 3'd4;
    localparam logic [2:0] REQ_REMOVE     = 3'd5;
    localparam logic [2:0] REQ_ACK_DEACT  = 3'd6;

    // switch modes
    localparam logic [1:0] SW_TARGET = 2'd0;
    localparam logic [1:0] SW_PREV   = 2'd1;
    localparam logic [1:0] SW_NEXT   = 2'd2;
    localparam logic [1:0] SW_BEST   = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOCHG    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // notification codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ACT   = 2'd1;
    localparam logic [1:0] EV_DEACT = 2'd2;
    localparam logic [1:0] EV_REM   = 2'd3;

    // what a scan over the focus order found
    typedef struct packed {
        logic match;
        logic vis0;
        logic vis1;
        logic lvis;
        logic best;
    } t_scan_flags;

endpackage

// ----- sv/input_focus_client_arbiter.sv -----
// input_focus_client_arbiter: circular focus order of client slots with sequencer
// depends on ifca_pkg and ifca_scan
//
// One request at a time; ready drops while a request is worked on. Connect,
// register pid and ack deactivated need no scan. Hide and lookups are bound by
// the scan unit that reads one order entry per cycle. Switch with two or more
// clients does one scan, then a rotation of one position per cycle; removing
// the head does a scan, shift, rescan and rotation. A finished result sits in
// an output register, so the next request can be taken while it waits.
module input_focus_client_arbiter import ifca_pkg::*; #(
    parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
    parameter int PID_BITS    = PID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_req_type,
    input  logic [3:0]          i_requester_handle,
    input  logic [PID_BITS-1:0] i_target_pid,
    input  logic [1:0]          i_switch_mode,
    input  logic [7:0]          i_hide_priority,
    input  logic                i_hide_flag,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_status,
    output logic [1:0]          o_event_code,
    output logic [3:0]          o_event_target,
    output logic [3:0]          o_assigned_handle,
    output logic [3:0]          o_active_handle,
    output logic                o_active_valid,
    output logic [4:0]          o_clients_now
);
    localparam int PW = $clog2(MAX_CLIENTS);
    localparam int CW = $clog2(MAX_CLIENTS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_WAIT1  = 4'd2;
    localparam logic [3:0] S_POST1  = 4'd3;
    localparam logic [3:0] S_RESCAN = 4'd4;
    localparam logic [3:0] S_WAIT2  = 4'd5;
    localparam logic [3:0] S_POST2  = 4'd6;
    localparam logic [3:0] S_ROT    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    // slot and order state
    logic [PW-1:0]       r_order [MAX_CLIENTS];
    logic [CW-1:0]       r_count;
    logic [MAX_CLIENTS-1:0] r_svalid;
    logic [PID_BITS-1:0] r_spid  [MAX_CLIENTS];
    logic                r_shid  [MAX_CLIENTS];
    logic [7:0]          r_sprio [MAX_CLIENTS];

    // request and result working registers
    logic [3:0]          r_state;
    logic [2:0]          r_type;
    logic [3:0]          r_req;
    logic [PID_BITS-1:0] r_pid;
    logic [1:0]          r_mode;
    logic [7:0]          r_hprio;
    logic                r_hflag;
    logic [1:0]          r_st, r_ev;
    logic [PW-1:0]       r_evt, r_asg, r_rot;
    logic                r_head_act;

    // output register
    logic                r_ovalid;
    logic [1:0]          r_ost, r_oev;
    logic [3:0]          r_oevt, r_oasg, r_oact;
    logic                r_oactv;
    logic [4:0]          r_ocnt;

    // scan unit hookup
    logic                w_scan_start, w_scan_busy, w_scan_done;
    logic [PW-1:0]       w_idx, w_elem;
    logic                w_hit;
    t_scan_flags         w_flags;
    logic [PW-1:0]       w_match_pos, w_vis0_pos, w_vis1_pos, w_lvis_pos, w_best_pos;
    logic [PID_BITS-1:0] w_key;
    logic                w_req_ok;
    logic [PW-1:0]       w_req_h;

    // connect helpers
    logic                w_free_found;
    logic [PW-1:0]       w_free;

    // switch target selection
    logic                w_sw_found;
    logic [PW-1:0]       w_sw_pos;

    assign w_req_ok = 32'(r_req) < MAX_CLIENTS;
    assign w_req_h  = PW'(r_req);
    assign w_key    = (r_type == REQ_DISCONNECT) ? '0 : r_pid;
    assign w_elem   = r_order[w_idx];
    assign w_hit    = (w_key != '0) ? (r_spid[w_elem] == w_key)
                                    : (w_req_ok && w_elem == w_req_h);

    ifca_scan #(
        .MAX_CLIENTS(MAX_CLIENTS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_scan_start),
        .i_count    (r_count),
        .o_idx      (w_idx),
        .o_busy     (w_scan_busy),
        .o_done     (w_scan_done),
        .i_hit      (w_hit),
        .i_hid      (r_shid[w_elem]),
        .i_prio     (r_sprio[w_elem]),
        .o_flags    (w_flags),
        .o_match_pos(w_match_pos),
        .o_vis0_pos (w_vis0_pos),
        .o_vis1_pos (w_vis1_pos),
        .o_lvis_pos (w_lvis_pos),
        .o_best_pos (w_best_pos)
    );

    assign w_scan_start = (r_state == S_EXEC &&
                           (r_type == REQ_DISCONNECT || r_type == REQ_REMOVE ||
                            r_type == REQ_HIDE ||
                            (r_type == REQ_SWITCH && r_count >= CW'(2))))
                          || (r_state == S_RESCAN);

    // lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free       = '0;
        for (int i = MAX_CLIENTS - 1; i >= 0; i--) begin
            if (!r_svalid[i]) begin
                w_free_found = 1'b1;
                w_free       = PW'(i);
            end
        end
    end

    // switch target by mode
    always_comb begin
        case (r_mode)
            SW_TARGET: begin w_sw_found = w_flags.match; w_sw_pos = w_match_pos; end
            SW_PREV:   begin w_sw_found = w_flags.lvis;  w_sw_pos = w_lvis_pos;  end
            SW_NEXT:   begin w_sw_found = w_flags.vis1;  w_sw_pos = w_vis1_pos;  end
            default:   begin w_sw_found = w_flags.best;  w_sw_pos = w_best_pos;  end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_svalid   <= '0;
            r_head_act <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_type     <= i_req_type;
                        r_req      <= i_requester_handle;
                        r_pid      <= i_target_pid;
                        r_mode     <= i_switch_mode;
                        r_hprio    <= i_hide_priority;
                        r_hflag    <= i_hide_flag;
                        r_st       <= ST_NOCHG;
                        r_ev       <= EV_NONE;
                        r_evt      <= '0;
                        r_asg      <= '0;
                        r_rot      <= '0;
                        r_head_act <= 1'b0;
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_type) inside
                        REQ_CONNECT: begin
                            if (r_count >= CW'(MAX_CLIENTS) || !w_free_found) begin
                                r_st <= ST_FULL;
                            end else begin
                                for (int i = 1; i < MAX_CLIENTS; i++) begin
                                    if (CW'(i) <= r_count) r_order[i] <= r_order[i-1];
                                end
                                r_order[0] <= w_free;
                                if (r_count != '0) begin
                                    r_ev  <= EV_DEACT;
                                    r_evt <= r_order[0];
                                end else begin
                                    r_ev  <= EV_ACT;
                                    r_evt <= w_free;
                                end
                                r_count          <= r_count + CW'(1);
                                r_svalid[w_free] <= 1'b1;
                                r_spid[w_free]   <= '0;
                                r_shid[w_free]   <= 1'b0;
                                r_sprio[w_free]  <= '0;
                                r_asg            <= w_free;
                                r_st             <= ST_DONE;
                            end
                            r_state <= S_OUT;
                        end
                        REQ_REG_PID: begin
                            if (w_req_ok && r_svalid[w_req_h]) begin
                                r_spid[w_req_h] <= r_pid;
                                r_st            <= ST_DONE;
                            end else begin
                                r_st <= ST_NOTFOUND;
                            end
                            r_state <= S_OUT;
                        end
                        REQ_ACK_DEACT: begin
                            if (r_count != '0) begin
                                r_st  <= ST_DONE;
                                r_ev  <= EV_ACT;
                                r_evt <= r_order[0];
                            end
                            r_state <= S_OUT;
                        end
                        REQ_DISCONNECT, REQ_REMOVE, REQ_HIDE: begin
                            r_state <= S_WAIT1;
                        end
                        REQ_SWITCH: begin
                            r_state <= (r_count >= CW'(2)) ? S_WAIT1 : S_OUT;
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_WAIT1: begin
                    if (w_scan_done) r_state <= S_POST1;
                end
                S_POST1: begin
                    r_state <= S_OUT;
                    case (r_type)
                        REQ_HIDE: begin
                            if (!w_flags.match) begin
                                r_st <= ST_NOTFOUND;
                            end else begin
                                r_sprio[r_order[w_match_pos]] <= r_hprio;
                                r_shid[r_order[w_match_pos]]  <= r_hflag;
                                r_st <= ST_DONE;
                            end
                        end
                        REQ_SWITCH: begin
                            if (r_mode == SW_TARGET && !w_flags.match) begin
                                r_st <= ST_NOTFOUND;
                            end else if (w_sw_found && w_sw_pos != '0) begin
                                r_rot   <= w_sw_pos;
                                r_st    <= ST_DONE;
                                r_ev    <= EV_DEACT;
                                r_evt   <= r_order[0];
                                r_state <= S_ROT;
                            end
                        end
                        default: begin
                            // disconnect or remove request
                            if (!w_flags.match) begin
                                r_st <= ST_NOTFOUND;
                            end else if (!w_req_ok || r_order[w_match_pos] != w_req_h) begin
                                r_st  <= ST_DONE;
                                r_ev  <= EV_REM;
                                r_evt <= r_order[w_match_pos];
                            end else begin
                                r_st <= ST_DONE;
                                for (int i = 0; i < MAX_CLIENTS - 1; i++) begin
                                    if (PW'(i) >= w_match_pos) r_order[i] <= r_order[i+1];
                                end
                                r_count                         <= r_count - CW'(1);
                                r_svalid[r_order[w_match_pos]]  <= 1'b0;
                                if (w_match_pos == '0 && r_count != CW'(1)) begin
                                    r_state <= S_RESCAN;
                                end
                            end
                        end
                    endcase
                end
                S_RESCAN: begin
                    r_state <= S_WAIT2;
                end
                S_WAIT2: begin
                    if (w_scan_done) r_state <= S_POST2;
                end
                S_POST2: begin
                    // focus to first visible, else best hidden
                    if (w_flags.vis0)      r_rot <= w_vis0_pos;
                    else if (w_flags.best) r_rot <= w_best_pos;
                    else                   r_rot <= '0;
                    r_head_act <= 1'b1;
                    r_ev       <= EV_ACT;
                    r_state    <= S_ROT;
                end
                S_ROT: begin
                    if (r_rot == '0) begin
                        if (r_head_act) r_evt <= r_order[0];
                        r_state <= S_OUT;
                    end else begin
                        for (int i = 0; i < MAX_CLIENTS - 1; i++) begin
                            if (CW'(i) + CW'(1) < r_count) r_order[i] <= r_order[i+1];
                        end
                        r_order[PW'(r_count - CW'(1))] <= r_order[0];
                        r_rot <= r_rot - PW'(1);
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register, loaded as the transaction finishes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_state == S_OUT && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
                r_ost    <= r_st;
                r_oev    <= r_ev;
                r_oevt   <= 4'(r_evt);
                r_oasg   <= 4'(r_asg);
                r_oact   <= (r_count != '0) ? 4'(r_order[0]) : 4'd0;
                r_oactv  <= (r_count != '0);
                r_ocnt   <= 5'(r_count);
            end
        end
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_status          = r_ost;
    assign o_event_code      = r_oev;
    assign o_event_target    = r_oevt;
    assign o_assigned_handle = r_oasg;
    assign o_active_handle   = r_oact;
    assign o_active_valid    = r_oactv;
    assign o_clients_now     = r_ocnt;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_CLIENTS))
        else $error("client count above capacity");
    a_idle_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT) |-> !w_scan_busy)
        else $error("scan running outside a request");
    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_oactv == (r_ocnt != 5'd0) || r_count > CW'(31)))
        else $error("active flag disagrees with client count");
`endif

endmodule

// ----- sv/ifca_scan.sv -----
// ifca_scan: walks the focus order one position per cycle
// finds first match, first visible, first and last visible past the head, and best hidden position
// depends on ifca_pkg
module ifca_scan import ifca_pkg::*; #(
    parameter int MAX_CLIENTS = MAX_CLIENTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [$clog2(MAX_CLIENTS+1)-1:0] i_count,
    output logic [$clog2(MAX_CLIENTS)-1:0]   o_idx,
    output logic                             o_busy,
    output logic                             o_done,
    input  logic                             i_hit,
    input  logic                             i_hid,
    input  logic [7:0]                       i_prio,
    output t_scan_flags                      o_flags,
    output logic [$clog2(MAX_CLIENTS)-1:0]   o_match_pos,
    output logic [$clog2(MAX_CLIENTS)-1:0]   o_vis0_pos,
    output logic [$clog2(MAX_CLIENTS)-1:0]   o_vis1_pos,
    output logic [$clog2(MAX_CLIENTS)-1:0]   o_lvis_pos,
    output logic [$clog2(MAX_CLIENTS)-1:0]   o_best_pos
);
    localparam int PW = $clog2(MAX_CLIENTS);
    localparam int CW = $clog2(MAX_CLIENTS + 1);

    logic              r_busy, r_done;
    logic [PW-1:0]     r_idx;
    t_scan_flags       r_flags;
    logic [PW-1:0]     r_match_pos, r_vis0_pos, r_vis1_pos, r_lvis_pos, r_best_pos;
    logic [7:0]        r_best_prio;
    logic [CW-1:0]     w_idx_ext;
    logic              w_in_range, w_last, w_first;

    assign w_idx_ext  = CW'(r_idx);
    assign w_in_range = w_idx_ext < i_count;
    assign w_last     = (w_idx_ext + CW'(1) >= i_count);
    assign w_first    = (r_idx == '0);

    // index and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + PW'(1);
                end
            end
        end
    end

    // accumulators, one element per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_start) begin
            r_flags <= '0;
        end else if (r_busy && w_in_range) begin
            if (!r_flags.match && i_hit) begin
                r_flags.match <= 1'b1;
                r_match_pos   <= r_idx;
            end
            if (!r_flags.vis0 && !i_hid) begin
                r_flags.vis0 <= 1'b1;
                r_vis0_pos   <= r_idx;
            end
            if (!r_flags.vis1 && !i_hid && !w_first) begin
                r_flags.vis1 <= 1'b1;
                r_vis1_pos   <= r_idx;
            end
            if (!i_hid && !w_first) begin
                r_flags.lvis <= 1'b1;
                r_lvis_pos   <= r_idx;
            end
            if (i_hid && (!r_flags.best || i_prio > r_best_prio)) begin
                r_flags.best <= 1'b1;
                r_best_pos   <= r_idx;
                r_best_prio  <= i_prio;
            end
        end
    end

    assign o_idx       = r_idx;
    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_flags     = r_flags;
    assign o_match_pos = r_match_pos;
    assign o_vis0_pos  = r_vis0_pos;
    assign o_vis1_pos  = r_vis1_pos;
    assign o_lvis_pos  = r_lvis_pos;
    assign o_best_pos  = r_best_pos;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("scan done without a scan");
    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("scan busy and done together");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start) |-> (w_in_range || i_count == '0))
        else $error("scan index past count");
`endif

endmodule
